[rtl/assert_macros.svh]
// Assertion macros shared by the displacement block; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk, switched off while rst is high.
`define THD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define THD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define THD_ASSERT(lbl, prop, msg)
`define THD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/thd_pkg.sv]
// Constants, types and datapath functions of the tidal harmonic displacement block.
package thd_pkg;

  localparam int PHASE_BITS      = 24;
  localparam int COEF_BITS       = 16;
  localparam int OFFSET_BITS     = 9;
  localparam int OUT_BITS        = 18;
  localparam int TRIG_BITS       = 16;
  localparam int FRAC_BITS       = 15;
  localparam int ANGLE_BITS      = 32;
  localparam int CORDIC_STEPS    = 18;
  localparam int STEPS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int XY_W            = 32;
  localparam int Z_W             = ANGLE_BITS;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 64;
  localparam int NUM_AXES        = 3;
  localparam int NUM_TERMS       = 4;
  localparam int PROD_W          = COEF_BITS + TRIG_BITS;
  localparam int SUM_W           = PROD_W + 2;
  localparam int ACC_W           = (SUM_W > OUT_BITS + FRAC_BITS + 1) ? SUM_W
                                                                     : OUT_BITS + FRAC_BITS + 1;
  localparam int COEF_PAD_W      = (NUM_TERMS * COEF_BITS > CFG_DATA_BITS) ?
                                   NUM_TERMS * COEF_BITS : CFG_DATA_BITS;

  // Pipeline stage positions.
  localparam int STG_PHASE   = 0;
  localparam int STG_TRIG    = CORDIC_STAGES + 1;
  localparam int STG_MUL     = CORDIC_STAGES + 2;
  localparam int STG_SUM     = CORDIC_STAGES + 3;
  localparam int STG_OUT     = CORDIC_STAGES + 4;
  localparam int PIPE_STAGES = CORDIC_STAGES + 5;

  // Axis and term positions.
  localparam int AXIS_NORTH = 0;
  localparam int AXIS_EAST  = 1;
  localparam int AXIS_UP    = 2;
  localparam int TERM_COS1  = 0;
  localparam int TERM_SIN1  = 1;
  localparam int TERM_COS2  = 2;
  localparam int TERM_SIN2  = 3;

  // Gain-compensated unit vector, 2^30 scaled by the inverse CORDIC gain.
  localparam logic signed [XY_W-1:0] X_INIT = XY_W'(652032874);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_COEF_UP,
    REG_COEF_NORTH,
    REG_COEF_EAST,
    REG_UT1_OFFSET
  } cfg_reg_t;

  typedef enum logic [1:0] {
    QUAD_I,
    QUAD_II,
    QUAD_III,
    QUAD_IV
  } quad_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    quad_t                  quad;
  } cordic_t;

  typedef struct packed {
    logic signed [TRIG_BITS-1:0] cos_v;
    logic signed [TRIG_BITS-1:0] sin_v;
  } trig_pair_t;

  // Arctangent of 2^-i, with 2^32 as one full turn.
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:       r = Z_W'(536870912);
      1:       r = Z_W'(316933406);
      2:       r = Z_W'(167458907);
      3:       r = Z_W'(85004756);
      4:       r = Z_W'(42667331);
      5:       r = Z_W'(21354465);
      6:       r = Z_W'(10679838);
      7:       r = Z_W'(5341269);
      8:       r = Z_W'(2670163);
      9:       r = Z_W'(1335087);
      10:      r = Z_W'(667544);
      11:      r = Z_W'(333772);
      12:      r = Z_W'(166886);
      13:      r = Z_W'(83443);
      14:      r = Z_W'(41722);
      15:      r = Z_W'(20861);
      16:      r = Z_W'(10430);
      17:      r = Z_W'(5215);
      default: r = '0;
    endcase
    return r;
  endfunction

  // The quadrant comes from the top two bits; the rest of the angle is rotated.
  function automatic cordic_t cordic_init(input logic [ANGLE_BITS-1:0] angle);
    cordic_t r;
    r.x    = X_INIT;
    r.y    = '0;
    r.z    = Z_W'(angle[ANGLE_BITS-3:0]);
    r.quad = quad_t'(angle[ANGLE_BITS-1:ANGLE_BITS-2]);
    return r;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t                r;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    r  = c;
    if (!c.z[Z_W-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - atan_entry(i);
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + atan_entry(i);
    end
    return r;
  endfunction

  // One pipeline stage worth of rotations, starting at rotation first.
  function automatic cordic_t cordic_stage(input cordic_t c, input int first);
    cordic_t r;
    r = c;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      if (first + j < CORDIC_STEPS) begin
        r = cordic_step(r, first + j);
      end
    end
    return r;
  endfunction

  function automatic logic signed [TRIG_BITS-1:0] round_trig(input logic signed [XY_W:0] v);
    logic signed [XY_W:0] r;
    logic signed [XY_W:0] hi;
    logic signed [XY_W:0] lo;
    hi = (XY_W+1)'((64'sd1 << (TRIG_BITS - 1)) - 1);
    lo = -(XY_W+1)'(64'sd1 << (TRIG_BITS - 1));
    r  = (v + (XY_W+1)'(64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return TRIG_BITS'(r);
  endfunction

  // Apply the quadrant by swapping and negating, then round to Q1.15.
  function automatic trig_pair_t trig_finish(input cordic_t c);
    trig_pair_t           r;
    logic signed [XY_W:0] xe;
    logic signed [XY_W:0] ye;
    logic signed [XY_W:0] cv;
    logic signed [XY_W:0] sv;
    xe = (XY_W+1)'(c.x);
    ye = (XY_W+1)'(c.y);
    case (c.quad)
      QUAD_I: begin
        cv = xe;
        sv = ye;
      end
      QUAD_II: begin
        cv = -ye;
        sv = xe;
      end
      QUAD_III: begin
        cv = -xe;
        sv = -ye;
      end
      default: begin
        cv = ye;
        sv = -xe;
      end
    endcase
    r.cos_v = round_trig(cv);
    r.sin_v = round_trig(sv);
    return r;
  endfunction

  // Field k of a packed coefficient register; bits beyond the register read as zero.
  function automatic logic signed [COEF_BITS-1:0] coef_term(
    input logic [CFG_DATA_BITS-1:0] packed_coefs,
    input int                       k
  );
    logic [COEF_PAD_W-1:0] p;
    p = COEF_PAD_W'(packed_coefs);
    return $signed(p[k*COEF_BITS +: COEF_BITS]);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] round_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'((64'sd1 << (OUT_BITS - 1)) - 1);
    lo = -ACC_W'(64'sd1 << (OUT_BITS - 1));
    r  = (v + ACC_W'(64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return OUT_BITS'(r);
  endfunction

endpackage

[rtl/tidal_harmonic_displacement.sv]
// Top level of the S1/S2 atmospheric tidal loading displacement pipeline.
//
// Usage:
//   Each input beat on day_phase carries a UTC time of day in units of 2^-24 day.
//   The block adds the UT1-UTC offset modulo one day, forms cos and sin of one
//   and two turns per day, and returns one output beat with the north, east and
//   up displacements in units of 1e-7 m, each a rounded sum of four products.
//   Coefficients and the offset are written through the cfg channel (index 0 up,
//   1 north, 2 east, 3 offset); cfg_ready is always high. Writes must be made
//   only while no beat is in flight; the block itself does not enforce this.
//   There are 11 register stages: phase, CORDIC, trig, product, sum and output.
//   A beat can enter on every cycle while in_stall is low, so throughput is one
//   beat per clock when nothing stalls; the CORDIC section (18 rotations, three
//   per stage, two angles side by side) sets the depth. When out_stall is high
//   the output beat holds, and stages behind it keep moving until they are
//   full; in_stall rises only once every stage holds a beat. Reset (rst,
//   synchronous) empties the pipeline and clears all configuration registers
//   to zero.
`include "assert_macros.svh"

module tidal_harmonic_displacement (
  input  logic                                          clk,
  input  logic                                          rst,
  // Input channel.
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic [thd_pkg::PHASE_BITS-1:0]                day_phase,
  // Output channel.
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic signed [thd_pkg::OUT_BITS-1:0]           north_disp,
  output logic signed [thd_pkg::OUT_BITS-1:0]           east_disp,
  output logic signed [thd_pkg::OUT_BITS-1:0]           up_disp,
  // Configuration write channel.
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic [thd_pkg::CFG_INDEX_BITS-1:0]            cfg_index,
  input  logic [thd_pkg::CFG_DATA_BITS-1:0]             cfg_data
);

  // Configuration registers.
  logic [thd_pkg::CFG_DATA_BITS-1:0] coef_up;
  logic [thd_pkg::CFG_DATA_BITS-1:0] coef_north;
  logic [thd_pkg::CFG_DATA_BITS-1:0] coef_east;
  logic [thd_pkg::OFFSET_BITS-1:0]   ut1_offset;

  // Per-stage valid bits and advance enables.
  logic [thd_pkg::PIPE_STAGES-1:0] v;
  logic [thd_pkg::PIPE_STAGES-1:0] en;
  logic [thd_pkg::PIPE_STAGES-1:0] v_next;

  // Phase stage.
  logic [thd_pkg::PHASE_BITS-1:0] phase;
  logic [thd_pkg::ANGLE_BITS-1:0] angle1;
  logic [thd_pkg::ANGLE_BITS-1:0] angle2;

  // CORDIC pipelines for one and two turns per day; entry 0 is the phase stage.
  thd_pkg::cordic_t c1 [thd_pkg::CORDIC_STAGES+1];
  thd_pkg::cordic_t c2 [thd_pkg::CORDIC_STAGES+1];

  // Trig, product and sum stages.
  thd_pkg::trig_pair_t                     trig1;
  thd_pkg::trig_pair_t                     trig2;
  logic signed [thd_pkg::TRIG_BITS-1:0]    trig_term [thd_pkg::NUM_TERMS];
  logic [thd_pkg::CFG_DATA_BITS-1:0]       axis_coef [thd_pkg::NUM_AXES];
  logic signed [thd_pkg::PROD_W-1:0]       prod_next [thd_pkg::NUM_AXES][thd_pkg::NUM_TERMS];
  logic signed [thd_pkg::PROD_W-1:0]       prod      [thd_pkg::NUM_AXES][thd_pkg::NUM_TERMS];
  logic signed [thd_pkg::ACC_W-1:0]        acc       [thd_pkg::NUM_AXES];

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_up    <= '0;
      coef_north <= '0;
      coef_east  <= '0;
      ut1_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (thd_pkg::cfg_reg_t'(cfg_index))
        thd_pkg::REG_COEF_UP:    coef_up    <= cfg_data;
        thd_pkg::REG_COEF_NORTH: coef_north <= cfg_data;
        thd_pkg::REG_COEF_EAST:  coef_east  <= cfg_data;
        thd_pkg::REG_UT1_OFFSET: ut1_offset <= cfg_data[thd_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it moves on.
  // Bubbles therefore collapse, and the input is only held off when every
  // stage holds a beat and the output is stalled.
  always_comb begin
    en[thd_pkg::STG_OUT] = !v[thd_pkg::STG_OUT] || !out_stall;
    for (int i = thd_pkg::STG_OUT - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[thd_pkg::STG_PHASE];
  assign out_valid = v[thd_pkg::STG_OUT];
  assign v_next    = {v[thd_pkg::PIPE_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < thd_pkg::PIPE_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v_next[i];
        end
      end
    end
  end

  // Phase: the signed offset wraps modulo one day, then scales to a 32-bit
  // angle where the full range is one turn. The second harmonic doubles it.
  assign phase  = day_phase + thd_pkg::PHASE_BITS'($signed(ut1_offset));
  assign angle1 = thd_pkg::ANGLE_BITS'(phase) << (thd_pkg::ANGLE_BITS - thd_pkg::PHASE_BITS);
  assign angle2 = angle1 << 1;

  always_ff @(posedge clk) begin
    if (en[thd_pkg::STG_PHASE]) begin
      c1[0] <= thd_pkg::cordic_init(angle1);
      c2[0] <= thd_pkg::cordic_init(angle2);
    end
  end

  // Rotation stages, a few CORDIC iterations each.
  for (genvar k = 1; k <= thd_pkg::CORDIC_STAGES; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en[k]) begin
        c1[k] <= thd_pkg::cordic_stage(c1[k-1], (k - 1) * thd_pkg::STEPS_PER_STAGE);
        c2[k] <= thd_pkg::cordic_stage(c2[k-1], (k - 1) * thd_pkg::STEPS_PER_STAGE);
      end
    end
  end

  // Quadrant fix-up and rounding to Q1.15.
  always_ff @(posedge clk) begin
    if (en[thd_pkg::STG_TRIG]) begin
      trig1 <= thd_pkg::trig_finish(c1[thd_pkg::CORDIC_STAGES]);
      trig2 <= thd_pkg::trig_finish(c2[thd_pkg::CORDIC_STAGES]);
    end
  end

  assign trig_term[thd_pkg::TERM_COS1] = trig1.cos_v;
  assign trig_term[thd_pkg::TERM_SIN1] = trig1.sin_v;
  assign trig_term[thd_pkg::TERM_COS2] = trig2.cos_v;
  assign trig_term[thd_pkg::TERM_SIN2] = trig2.sin_v;

  assign axis_coef[thd_pkg::AXIS_NORTH] = coef_north;
  assign axis_coef[thd_pkg::AXIS_EAST]  = coef_east;
  assign axis_coef[thd_pkg::AXIS_UP]    = coef_up;

  // Twelve products, one 16x16 multiplier each, registered.
  for (genvar a = 0; a < thd_pkg::NUM_AXES; a++) begin : g_axis
    for (genvar t = 0; t < thd_pkg::NUM_TERMS; t++) begin : g_term
      assign prod_next[a][t] = thd_pkg::PROD_W'(thd_pkg::coef_term(axis_coef[a], t))
                             * thd_pkg::PROD_W'(trig_term[t]);
      always_ff @(posedge clk) begin
        if (en[thd_pkg::STG_MUL]) begin
          prod[a][t] <= prod_next[a][t];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[thd_pkg::STG_SUM]) begin
        acc[a] <= thd_pkg::ACC_W'(prod[a][thd_pkg::TERM_COS1])
                + thd_pkg::ACC_W'(prod[a][thd_pkg::TERM_SIN1])
                + thd_pkg::ACC_W'(prod[a][thd_pkg::TERM_COS2])
                + thd_pkg::ACC_W'(prod[a][thd_pkg::TERM_SIN2]);
      end
    end
  end

  // Output register: round away the Q1.15 scale and saturate to 18 bits.
  always_ff @(posedge clk) begin
    if (en[thd_pkg::STG_OUT]) begin
      north_disp <= thd_pkg::round_out(acc[thd_pkg::AXIS_NORTH]);
      east_disp  <= thd_pkg::round_out(acc[thd_pkg::AXIS_EAST]);
      up_disp    <= thd_pkg::round_out(acc[thd_pkg::AXIS_UP]);
    end
  end

  // The input is held off only when the whole pipeline is occupied.
  `THD_ASSERT(a_stall_only_when_full, in_stall |-> (&v), "input stalled with room in pipeline")

  // Beats in flight change only by accepted inputs and delivered outputs.
  `THD_ASSERT(a_beat_count,
              !rst |=> $countones(v) == $past($countones(v)) + $past(in_valid && !in_stall)
                                        - $past(out_valid && !out_stall),
              "beat lost or duplicated in pipeline")

  // Reset leaves the pipeline empty.
  `THD_ASSERT_ALWAYS(a_reset_empties, $past(rst) |-> (v == '0), "pipeline not empty after reset")

endmodule
